FILE: src/priority_command_mux_with_timeout_unit_assert.svh
`ifndef PRIORITY_COMMAND_MUX_WITH_TIMEOUT_UNIT_ASSERT_SVH
`define PRIORITY_COMMAND_MUX_WITH_TIMEOUT_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define PCMT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define PCMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pcmt_pkg.sv
package pcmt_pkg;

    localparam int SOURCES_DEF      = 16;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int TIME_BITS_DEF    = 32;

    localparam int ID_W  = 4;
    localparam int TMO_W = 16;
    localparam int PAY_W = 64;
    localparam int NOW_W = 32;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [TMO_W-1:0] tmo_t;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CAUSE_ARRIVAL = 1'b0;
    localparam logic CAUSE_TICK    = 1'b1;

endpackage

FILE: src/priority_command_mux_with_timeout_unit.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  opcode, source_id, life_ms, payload, now_ms
// m_       out        m_valid / m_ready  out_id, out_life_ms, out_payload, out_cause
//
// An item is taken in the idle state; the scan then makes one slot memory read per source
// through the single read port, registers each read word and checks it, and a decision
// state follows. An arrival from a source at or above SOURCES skips the scan.
// Reset clears the slot valid bits and the forwarded mark at once; there is no clearing pass.
// A waiting result does not hold off the next item; only the decision cycle waits while
// the output register is still full.
module priority_command_mux_with_timeout_unit
    import pcmt_pkg::*;
#(
    parameter int SOURCES      = SOURCES_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_opcode,
    input  logic [ID_W-1:0]  s_source_id,
    input  logic [TMO_W-1:0] s_life_ms,
    input  logic [PAY_W-1:0] s_payload,
    input  logic [NOW_W-1:0] s_now_ms,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ID_W-1:0]  m_out_id,
    output logic [TMO_W-1:0] m_out_life_ms,
    output logic [PAY_W-1:0] m_out_payload,
    output logic             m_out_cause
);

    localparam int IDX_W = $clog2(SOURCES);
    localparam int MEM_W = TIME_BITS + TMO_W + PAYLOAD_BITS;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [TIME_BITS-1:0]    tm_t;
    typedef logic [PAYLOAD_BITS-1:0] pl_t;
    typedef logic [MEM_W-1:0]        word_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   op_reg, op_next;
    idx_t   id_reg, id_next;
    tm_t    now_reg, now_next;
    idx_t   cnt_reg, cnt_next;
    logic   issue_reg, issue_next;
    logic   rd_vld_reg, rd_vld_next;
    idx_t   rd_idx_reg, rd_idx_next;
    word_t  rd_word_reg;
    logic   found_reg, found_next;
    idx_t   best_idx_reg, best_idx_next;
    tmo_t   best_tmo_reg, best_tmo_next;
    pl_t    best_pl_reg, best_pl_next;
    logic   last_known_reg, last_known_next;
    id_t    last_id_reg, last_id_next;
    logic [SOURCES-1:0] valid_reg, valid_next;

    logic   m_valid_reg, m_valid_next;
    id_t    m_id_reg, m_id_next;
    tmo_t   m_tmo_reg, m_tmo_next;
    logic [PAY_W-1:0] m_pl_reg, m_pl_next;
    logic   m_cause_reg, m_cause_next;

    word_t  slot_mem [SOURCES];

    logic   s_xfer;
    logic   in_range;
    logic   wr_en;
    idx_t   s_idx;
    tm_t    rd_arr;
    tmo_t   rd_tmo;
    pl_t    rd_pl;
    tm_t    elapsed;
    logic   expired;
    logic   slot_on;
    logic   want;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign s_xfer   = s_valid && s_ready;
    assign in_range = (32'(s_source_id) < SOURCES);
    assign s_idx    = idx_t'(s_source_id);
    assign wr_en    = s_xfer && (s_opcode == OP_CMD) && in_range;

    assign rd_arr  = rd_word_reg[MEM_W-1 -: TIME_BITS];
    assign rd_tmo  = rd_word_reg[PAYLOAD_BITS +: TMO_W];
    assign rd_pl   = rd_word_reg[PAYLOAD_BITS-1:0];
    assign elapsed = now_reg - rd_arr;
    assign expired = (rd_tmo != '0) && (elapsed > tm_t'(rd_tmo));
    assign slot_on = valid_reg[rd_idx_reg];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[s_idx] <= {tm_t'(s_now_ms), s_life_ms, pl_t'(s_payload)};
        end
        if (issue_reg) begin
            rd_word_reg <= slot_mem[cnt_reg];
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        rd_vld_next     = issue_reg;
        rd_idx_next     = cnt_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_tmo_next   = best_tmo_reg;
        best_pl_next    = best_pl_reg;
        last_known_next = last_known_reg;
        last_id_next    = last_id_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_id_next       = m_id_reg;
        m_tmo_next      = m_tmo_reg;
        m_pl_next       = m_pl_reg;
        m_cause_next    = m_cause_reg;
        want            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    id_next    = s_idx;
                    now_next   = tm_t'(s_now_ms);
                    found_next = 1'b0;
                    cnt_next   = '0;
                    if ((s_opcode == OP_CMD) && !in_range) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SCAN;
                        issue_next = 1'b1;
                    end
                    if (wr_en) begin
                        valid_next[s_idx] = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == idx_t'(SOURCES - 1)) begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_vld_reg) begin
                    if ((op_reg == OP_TICK) && slot_on && expired) begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end
                    if (slot_on && !expired && !found_reg) begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_tmo_next = rd_tmo;
                        best_pl_next  = rd_pl;
                    end
                    if (rd_idx_reg == idx_t'(SOURCES - 1)) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (op_reg == OP_CMD) begin
                    want = found_reg && (best_idx_reg == id_reg);
                end else if (!found_reg) begin
                    last_known_next = 1'b0;
                end else begin
                    want = !(last_known_reg && (last_id_reg == id_t'(best_idx_reg)));
                end
                if (!want) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_id_next       = id_t'(best_idx_reg);
                    m_tmo_next      = best_tmo_reg;
                    m_pl_next       = PAY_W'(best_pl_reg);
                    m_cause_next    = (op_reg == OP_CMD) ? CAUSE_ARRIVAL : CAUSE_TICK;
                    last_known_next = 1'b1;
                    last_id_next    = id_t'(best_idx_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            last_known_reg <= 1'b0;
            last_id_reg    <= '0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            rd_vld_reg     <= rd_vld_next;
            found_reg      <= found_next;
            last_known_reg <= last_known_next;
            last_id_reg    <= last_id_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        now_reg      <= now_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_tmo_reg <= best_tmo_next;
        best_pl_reg  <= best_pl_next;
        m_id_reg     <= m_id_next;
        m_tmo_reg    <= m_tmo_next;
        m_pl_reg     <= m_pl_next;
        m_cause_reg  <= m_cause_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_id      = m_id_reg;
    assign m_out_life_ms = m_tmo_reg;
    assign m_out_payload = m_pl_reg;
    assign m_out_cause   = m_cause_reg;

endmodule

FILE: src/pcmt_checker.sv
`include "priority_command_mux_with_timeout_unit_assert.svh"

module pcmt_checker
    import pcmt_pkg::*;
#(
    parameter int SOURCES = SOURCES_DEF
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ID_W-1:0]  m_out_id,
    input logic [TMO_W-1:0] m_out_life_ms,
    input logic [PAY_W-1:0] m_out_payload,
    input logic             m_out_cause
);

    logic [ID_W+TMO_W+PAY_W:0] m_word;

    assign m_word = {m_out_id, m_out_life_ms, m_out_payload, m_out_cause};

    `PCMT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word), "stalled output transfer changed")
    `PCMT_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after a transfer")
    `PCMT_ASSERT_NOW(a_out_id_range, aclk, aresetn, m_valid, 32'(m_out_id) < SOURCES, "forwarded source outside the slot range")

endmodule

bind priority_command_mux_with_timeout_unit pcmt_checker #(.SOURCES(SOURCES)) u_pcmt_checker (.*);

FILE: tb/priority_command_mux_with_timeout_unit_test.sv
`timescale 1ns / 1ps

module priority_command_mux_with_timeout_unit_test;
    import pcmt_pkg::*;

    localparam int SLOTS          = SOURCES_DEF;
    localparam int SCRIPT_ROWS    = 22;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic             op;
        id_t              sid;
        tmo_t             tmo;
        logic [PAY_W-1:0] pay;
        logic [NOW_W-1:0] now;
    } mux_input_t;

    typedef struct packed {
        id_t              id;
        tmo_t             tmo;
        logic [PAY_W-1:0] pay;
        logic             cause;
    } fwd_t;

    typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_kind_t;

    typedef struct {
        mux_input_t  item;
        check_kind_t kind;
        fwd_t        given;
    } script_row_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_opcode;
    logic [ID_W-1:0]  s_source_id;
    logic [TMO_W-1:0] s_life_ms;
    logic [PAY_W-1:0] s_payload;
    logic [NOW_W-1:0] s_now_ms;
    logic             m_valid;
    logic             m_ready;
    logic [ID_W-1:0]  m_out_id;
    logic [TMO_W-1:0] m_out_life_ms;
    logic [PAY_W-1:0] m_out_payload;
    logic             m_out_cause;

    bit               slot_on [SLOTS];
    tmo_t             slot_tmo [SLOTS];
    logic [PAY_W-1:0] slot_pay [SLOTS];
    logic [NOW_W-1:0] slot_arr [SLOTS];
    bit               fwd_known;
    id_t              fwd_last;

    fwd_t             pending_forwards [$];
    fwd_t             expected_fwd;
    script_row_t      script [SCRIPT_ROWS];
    logic [NOW_W-1:0] clock_ms;
    int               sender_idle_pct   = 35;
    int               receiver_idle_pct = 86;
    int               mismatches        = 0;
    int               stall_cycles      = 0;

    priority_command_mux_with_timeout_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_source_id   (s_source_id),
        .s_life_ms     (s_life_ms),
        .s_payload     (s_payload),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_id      (m_out_id),
        .m_out_life_ms (m_out_life_ms),
        .m_out_payload (m_out_payload),
        .m_out_cause   (m_out_cause)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit slot_expired(int s, logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        elapsed = now - slot_arr[s];
        return (slot_tmo[s] != '0) && (elapsed > NOW_W'(slot_tmo[s]));
    endfunction

    task automatic predict_forward(input mux_input_t it, output bit fwd, output fwd_t res);
        int first;
        int s;
        fwd   = 1'b0;
        res   = '0;
        first = -1;
        if (it.op == OP_CMD) begin
            slot_on[it.sid]  = 1'b1;
            slot_tmo[it.sid] = it.tmo;
            slot_pay[it.sid] = it.pay;
            slot_arr[it.sid] = it.now;
            for (s = 0; s < SLOTS && first < 0; s++) begin
                if (slot_on[s] && !slot_expired(s, it.now))
                    first = s;
            end
            if (first == int'(it.sid)) begin
                fwd       = 1'b1;
                fwd_known = 1'b1;
                fwd_last  = it.sid;
                res       = '{it.sid, it.tmo, it.pay, CAUSE_ARRIVAL};
            end
        end else begin
            for (s = 0; s < SLOTS; s++) begin
                if (slot_on[s] && slot_expired(s, it.now))
                    slot_on[s] = 1'b0;
                else if (slot_on[s] && first < 0)
                    first = s;
            end
            if (first < 0) begin
                fwd_known = 1'b0;
            end else if (!fwd_known || fwd_last != id_t'(first)) begin
                fwd       = 1'b1;
                fwd_known = 1'b1;
                fwd_last  = id_t'(first);
                res       = '{id_t'(first), slot_tmo[first], slot_pay[first], CAUSE_TICK};
            end
        end
    endtask

    task automatic send_item(input mux_input_t it, input check_kind_t kind, input fwd_t given);
        bit   fwd;
        fwd_t res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_opcode    <= it.op;
        s_source_id <= it.sid;
        s_life_ms   <= it.tmo;
        s_payload   <= it.pay;
        s_now_ms    <= it.now;
        do @(posedge aclk); while (!s_ready);
        predict_forward(it, fwd, res);
        if (kind == CHK_GIVEN)
            pending_forwards.push_back(given);
        else if (kind == CHK_MODEL && fwd)
            pending_forwards.push_back(res);
    endtask

    task automatic drain_forwards();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_forwards.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int count);
        mux_input_t it;
        int         pick;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 90)
                clock_ms += $urandom_range(0, 150);
            else if (pick < 95)
                clock_ms = $urandom;
            else
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
            it.op  = ($urandom_range(0, 99) < 35) ? OP_TICK : OP_CMD;
            it.sid = id_t'($urandom_range(0, SLOTS - 1));
            pick   = $urandom_range(0, 99);
            if (pick < 15)
                it.tmo = '0;
            else if (pick < 85)
                it.tmo = tmo_t'($urandom_range(1, 400));
            else
                it.tmo = tmo_t'($urandom_range(0, 65535));
            it.pay = {$urandom, $urandom};
            it.now = clock_ms;
            send_item(it, CHK_MODEL, '0);
        end
        drain_forwards();
    endtask

    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_forwards.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transfer: id %0d timeout %0d payload %h cause %0d",
                             m_out_id, m_out_life_ms, m_out_payload, m_out_cause);
            end else begin
                expected_fwd = pending_forwards.pop_front();
                if (m_out_id !== expected_fwd.id || m_out_life_ms !== expected_fwd.tmo ||
                    m_out_payload !== expected_fwd.pay || m_out_cause !== expected_fwd.cause) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected id %0d timeout %0d payload %h cause %0d",
                                 expected_fwd.id, expected_fwd.tmo, expected_fwd.pay,
                                 expected_fwd.cause);
                        $display("          actual   id %0d timeout %0d payload %h cause %0d",
                                 m_out_id, m_out_life_ms, m_out_payload, m_out_cause);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = OP_CMD;
        s_source_id = '0;
        s_life_ms   = '0;
        s_payload   = '0;
        s_now_ms    = '0;
        m_ready     = 1'b0;
        clock_ms    = '0;

        script[0]  = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'd0}, CHK_NONE, '0};
        script[1]  = '{'{OP_CMD,  4'd15, 16'd0,    64'd0, 32'd0}, CHK_GIVEN,
                       '{4'd15, 16'd0, 64'd0, CAUSE_ARRIVAL}};
        script[2]  = '{'{OP_CMD,  4'd0,  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10}, CHK_GIVEN,
                       '{4'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, CAUSE_ARRIVAL}};
        script[3]  = '{'{OP_CMD,  4'd5,  16'd100,  64'h0123_4567_89AB_CDEF, 32'd20},
                       CHK_NONE, '0};
        script[4]  = '{'{OP_TICK, 4'd15, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd30},
                       CHK_NONE, '0};
        script[5]  = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'd65546}, CHK_GIVEN,
                       '{4'd15, 16'd0, 64'd0, CAUSE_TICK}};
        script[6]  = '{'{OP_CMD,  4'd3,  16'd50,   64'hA5A5_A5A5_A5A5_A5A5, 32'd100000},
                       CHK_MODEL, '0};
        script[7]  = '{'{OP_CMD,  4'd7,  16'd10,   64'h5A5A_5A5A_5A5A_5A5A, 32'd100010},
                       CHK_MODEL, '0};
        script[8]  = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'd100051}, CHK_MODEL, '0};
        script[9]  = '{'{OP_CMD,  4'd2,  16'd1,    64'h0000_0000_0000_0001, 32'd200000},
                       CHK_MODEL, '0};
        script[10] = '{'{OP_CMD,  4'd4,  16'd0,    64'h8000_0000_0000_0000, 32'd200002},
                       CHK_MODEL, '0};
        script[11] = '{'{OP_CMD,  4'd1,  16'd1000, 64'hDEAD_BEEF_0BAD_F00D, 32'hFFFF_FFF0},
                       CHK_MODEL, '0};
        script[12] = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'h0000_0010}, CHK_MODEL, '0};
        script[13] = '{'{OP_CMD,  4'd0,  16'd500,  64'h1357_9BDF_0246_8ACE, 32'h0000_1000},
                       CHK_MODEL, '0};
        script[14] = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'h0000_0F00}, CHK_MODEL, '0};
        script[15] = '{'{OP_CMD,  4'd4,  16'd1,    64'h7FFF_FFFF_FFFF_FFFE, 32'h0000_2000},
                       CHK_MODEL, '0};
        script[16] = '{'{OP_CMD,  4'd15, 16'd1,    64'h0F0F_0F0F_0F0F_0F0F, 32'h0000_2000},
                       CHK_MODEL, '0};
        script[17] = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'h0000_3000}, CHK_NONE, '0};
        script[18] = '{'{OP_TICK, 4'd9,  16'd7,    64'd3, 32'h0000_3001}, CHK_NONE, '0};
        script[19] = '{'{OP_CMD,  4'd9,  16'd0,    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF},
                       CHK_MODEL, '0};
        script[20] = '{'{OP_CMD,  4'd8,  16'hFFFF, 64'd0, 32'd0}, CHK_MODEL, '0};
        script[21] = '{'{OP_TICK, 4'd0,  16'd0,    64'd0, 32'h7FFF_FFFF}, CHK_MODEL, '0};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_item(script[r].item, script[r].kind, script[r].given);
        drain_forwards();

        run_phase(35, 86, 160);
        run_phase(86, 35, 160);
        run_phase(0, 0, 160);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_forwards.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/pcmt_pkg.sv
src/priority_command_mux_with_timeout_unit.sv
src/pcmt_checker.sv
tb/priority_command_mux_with_timeout_unit_test.sv
